// ===== design/cbsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbsm_pkg
// Shared types and codes for the cartridge bank-switch mapper.
// ----------------------------------------------------------------------------
package cbsm_pkg;

	localparam int unsigned TYPE_W = 4;
	localparam int unsigned ROMSZ_W = 21;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned BANK_W = 8;
	localparam int unsigned WIN_W = 2;
	localparam int unsigned OFS_W = 23;
	localparam int unsigned HADDR_W = 14;
	localparam int unsigned CFG_IDX_W = 2;

	// mapper type codes
	localparam logic [TYPE_W-1:0] MT_NORMAL     = 4'd0;
	localparam logic [TYPE_W-1:0] MT_FLAT_RAM   = 4'd1;
	localparam logic [TYPE_W-1:0] MT_SUPERCART  = 4'd2;
	localparam logic [TYPE_W-1:0] MT_LARGE      = 4'd3;
	localparam logic [TYPE_W-1:0] MT_SC_RAM     = 4'd4;
	localparam logic [TYPE_W-1:0] MT_SC_RAMX2   = 4'd5;
	localparam logic [TYPE_W-1:0] MT_SC_ROM     = 4'd6;
	localparam logic [TYPE_W-1:0] MT_ABSOLUTE   = 4'd7;
	localparam logic [TYPE_W-1:0] MT_HOTSPOT    = 4'd8;
	localparam logic [TYPE_W-1:0] MT_FLAT_ROM   = 4'd9;
	localparam logic [TYPE_W-1:0] MT_BANKSETS   = 4'd10;
	localparam logic [TYPE_W-1:0] MT_BS_RAM     = 4'd11;
	localparam logic [TYPE_W-1:0] MT_BS_HALTRAM = 4'd12;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAPPER_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROM_SIZE    = 2'd1;

	// window codes
	localparam logic [WIN_W-1:0] WIN_4000 = 2'd0;
	localparam logic [WIN_W-1:0] WIN_8000 = 2'd1;
	localparam logic [WIN_W-1:0] WIN_A000 = 2'd2;

	localparam logic [BANK_W-1:0] BANK_NONE = 8'hFF;
	localparam logic [ADDR_W-1:0] ADDR_LAST = 16'hFFFF;
	localparam logic [ADDR_W-1:0] ADDR_ABS_SWITCH = 16'h8000;

	typedef struct packed {
		logic [BANK_W-1:0] current_bank;
		logic              half_bit5;
		logic              half_ffff;
	} map_state_t;

	typedef struct packed {
		logic               rom_remap;
		logic [WIN_W-1:0]   window_select;
		logic [BANK_W-1:0]  rom_bank;
		logic               exram_swap;
		logic               exram_half;
		logic               image_load;
		logic [OFS_W-1:0]   image_offset;
		logic               halt_write;
		logic [HADDR_W-1:0] halt_addr;
		logic [DATA_W-1:0]  halt_data;
	} map_result_t;

endpackage
`default_nettype wire

// ===== design/cbsm_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbsm_decode
// Decode of one bus write against the mapper type and the mapping state.
// ----------------------------------------------------------------------------
module cbsm_decode (
	input  wire logic [cbsm_pkg::TYPE_W-1:0]  mapper_type,
	input  wire logic [cbsm_pkg::ROMSZ_W-1:0] rom_size_bytes,
	input  wire logic [cbsm_pkg::ADDR_W-1:0]  addr,
	input  wire logic [cbsm_pkg::DATA_W-1:0]  data,
	input  wire cbsm_pkg::map_state_t         cur,
	output cbsm_pkg::map_state_t              nxt,
	output cbsm_pkg::map_result_t             res
);

	logic                          bank_area;
	logic                          map_en;
	logic [cbsm_pkg::WIN_W-1:0]    map_win;
	logic [cbsm_pkg::BANK_W-1:0]   map_bank;
	logic                          sw5_en;
	logic                          swf_en;
	logic                          sw_half;
	cbsm_pkg::map_result_t         res_dec;

	assign bank_area = (addr[15:14] == 2'b10);

	always_comb begin
		res_dec  = '0;
		map_en   = 1'b0;
		map_win  = cbsm_pkg::WIN_4000;
		map_bank = '0;
		sw5_en   = 1'b0;
		swf_en   = 1'b0;
		sw_half  = 1'b0;

		unique case (mapper_type) inside
			cbsm_pkg::MT_SUPERCART, cbsm_pkg::MT_SC_RAM, cbsm_pkg::MT_SC_RAMX2,
			cbsm_pkg::MT_SC_ROM: begin
				if (bank_area) begin
					map_en   = 1'b1;
					map_win  = cbsm_pkg::WIN_8000;
					map_bank = data;
					if (mapper_type == cbsm_pkg::MT_SC_RAMX2) begin
						sw5_en   = 1'b1;
						sw_half  = data[5];
						map_bank = {3'b000, data[4:0]};
					end
				end else if (addr == cbsm_pkg::ADDR_LAST) begin
					swf_en  = 1'b1;
					sw_half = data[0];
				end
			end
			cbsm_pkg::MT_LARGE: begin
				map_en   = bank_area;
				map_win  = cbsm_pkg::WIN_8000;
				map_bank = data + 8'd1;
			end
			cbsm_pkg::MT_ABSOLUTE: begin
				map_en   = (addr == cbsm_pkg::ADDR_ABS_SWITCH) && (data == 8'd1 || data == 8'd2);
				map_win  = cbsm_pkg::WIN_4000;
				map_bank = data - 8'd1;
			end
			cbsm_pkg::MT_HOTSPOT: begin
				// hotspots sit in the top 128 bytes
				map_en   = &addr[15:7];
				map_win  = cbsm_pkg::WIN_A000;
				map_bank = {5'b00000, addr[2:0]};
			end
			cbsm_pkg::MT_BANKSETS, cbsm_pkg::MT_BS_RAM, cbsm_pkg::MT_BS_HALTRAM: begin
				if (bank_area) begin
					map_en               = 1'b1;
					map_win              = cbsm_pkg::WIN_8000;
					map_bank             = data;
					res_dec.image_load   = 1'b1;
					res_dec.image_offset = {3'b000, rom_size_bytes[cbsm_pkg::ROMSZ_W-1:1]}
						+ {1'b0, data, 14'b0};
				end else if (mapper_type == cbsm_pkg::MT_BS_HALTRAM && addr[15:14] == 2'b11)
				begin
					res_dec.halt_write = 1'b1;
					res_dec.halt_addr  = addr[cbsm_pkg::HADDR_W-1:0];
					res_dec.halt_data  = data;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res = res_dec;
		nxt = cur;
		if (map_en && map_bank != cur.current_bank) begin
			nxt.current_bank = map_bank;
			res.rom_remap     = 1'b1;
			res.window_select = map_win;
			res.rom_bank      = map_bank;
		end
		if (sw5_en && sw_half != cur.half_bit5) begin
			nxt.half_bit5  = sw_half;
			res.exram_swap = 1'b1;
			res.exram_half = sw_half;
		end
		if (swf_en && sw_half != cur.half_ffff) begin
			nxt.half_ffff  = sw_half;
			res.exram_swap = 1'b1;
			res.exram_half = sw_half;
		end
	end

endmodule
`default_nettype wire

// ===== design/cartridge_bank_switch_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper
// Cartridge mapper: turns CPU bus writes into bank, RAM-half and halt-RAM events.
// ----------------------------------------------------------------------------
// Each accepted word is one CPU write (address, data). The block takes one word
// every clock while in_stall is low and delivers exactly one result word per
// write. A word passes from the input register through the one decode stage
// into the result register. The mapping state (current bank, the two RAM-half
// trackers) is read by the decode stage and updated as the result register is
// loaded, so back-to-back writes see each other's effect. Result fields that
// carry no meaning (bank with no remap, half with no swap, offset with no image
// load, halt address/data with no halt write) are zero. The configuration
// registers (index 0 mapper type, index 1 ROM size) are always ready; the user
// is to write them only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cbsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cbsm_pkg::ROMSZ_W-1:0]       cfg_data,
	// write words in
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [cbsm_pkg::ADDR_W-1:0]        bus_address,
	input  wire logic [cbsm_pkg::DATA_W-1:0]        bus_data,
	// result words out
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    rom_remap,
	output logic [cbsm_pkg::WIN_W-1:0]              window_select,
	output logic [cbsm_pkg::BANK_W-1:0]             rom_bank,
	output logic                                    exram_swap,
	output logic                                    exram_half,
	output logic                                    image_load,
	output logic [cbsm_pkg::OFS_W-1:0]              image_offset,
	output logic                                    halt_write,
	output logic [cbsm_pkg::HADDR_W-1:0]            halt_addr,
	output logic [cbsm_pkg::DATA_W-1:0]             halt_data
);

	logic [cbsm_pkg::TYPE_W-1:0]  mapper_type_q;
	logic [cbsm_pkg::ROMSZ_W-1:0] rom_size_q;
	cbsm_pkg::map_state_t         state_q;
	cbsm_pkg::map_state_t         state_nxt;
	cbsm_pkg::map_result_t        res_nxt;
	cbsm_pkg::map_result_t        res_s2;

	logic                         valid_s1;
	logic [cbsm_pkg::ADDR_W-1:0]  addr_s1;
	logic [cbsm_pkg::DATA_W-1:0]  data_s1;
	logic                         valid_s2;

	logic                         adv_s2;
	logic                         take_s1;

	// Configuration: always ready, unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_type_q <= cbsm_pkg::MT_NORMAL;
			rom_size_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbsm_pkg::REG_MAPPER_TYPE: mapper_type_q <= cfg_data[cbsm_pkg::TYPE_W-1:0];
				cbsm_pkg::REG_ROM_SIZE:    rom_size_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the decode stage when the result register is empty or being drained.
	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	// Stall the input only when the input register holds a word that cannot move.
	assign in_stall = valid_s1 && !adv_s2;
	assign take_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			addr_s1 <= bus_address;
			data_s1 <= bus_data;
		end
	end

	cbsm_decode u_decode (
		.mapper_type    (mapper_type_q),
		.rom_size_bytes (rom_size_q),
		.addr           (addr_s1),
		.data           (data_s1),
		.cur            (state_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// Mapping state moves only when the decoded word is committed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.current_bank <= cbsm_pkg::BANK_NONE;
			state_q.half_bit5    <= 1'b0;
			state_q.half_ffff    <= 1'b0;
		end else if (adv_s2) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Hold the result while stalled.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign rom_remap     = res_s2.rom_remap;
	assign window_select = res_s2.window_select;
	assign rom_bank      = res_s2.rom_bank;
	assign exram_swap    = res_s2.exram_swap;
	assign exram_half    = res_s2.exram_half;
	assign image_load    = res_s2.image_load;
	assign image_offset  = res_s2.image_offset;
	assign halt_write    = res_s2.halt_write;
	assign halt_addr     = res_s2.halt_addr;
	assign halt_data     = res_s2.halt_data;

endmodule
`default_nettype wire

// ===== design/cbsm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbsm_checker
// Port-level checks for the cartridge bank-switch mapper.
// ----------------------------------------------------------------------------
module cbsm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic                           rom_remap,
	input wire logic [cbsm_pkg::WIN_W-1:0]     window_select,
	input wire logic [cbsm_pkg::BANK_W-1:0]    rom_bank,
	input wire logic                           exram_swap,
	input wire logic                           image_load,
	input wire logic [cbsm_pkg::OFS_W-1:0]     image_offset,
	input wire logic                           halt_write
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rom_bank) && $stable(image_offset)
		&& $stable(rom_remap) && $stable(halt_write))
		else $error("result word changed while stalled");

	// input backs up only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// a halt RAM write never coincides with a bank or image event
	a_halt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halt_write |-> !rom_remap && !image_load && !exram_swap)
		else $error("halt write mixed with mapping event");

	// no remap leaves bank and window at zero
	a_no_remap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rom_remap |-> rom_bank == '0 && window_select == cbsm_pkg::WIN_4000)
		else $error("bank fields set without remap");

endmodule

bind cartridge_bank_switch_mapper cbsm_checker u_cbsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.rom_remap     (rom_remap),
	.window_select (window_select),
	.rom_bank      (rom_bank),
	.exram_swap    (exram_swap),
	.image_load    (image_load),
	.image_offset  (image_offset),
	.halt_write    (halt_write)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cartridge bank-switch mapper.
// ----------------------------------------------------------------------------
// A short directed pass visits a set of mapper types and their corner cases. A long
// random pass follows: a fresh mapper type and ROM size for each block of
// writes, addresses aimed at the bank window, the last address, the hotspot
// page and the halt RAM area, and data bytes that repeat banks often.
// Each accepted write word is decoded by a local model of the mapper. Each
// result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	import cbsm_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned RANDOM_WRITES = 1650;
	localparam int unsigned SEGMENT_WRITES = 50;
	localparam int unsigned IGNORED_SEGMENT_WRITES = 12;
	localparam int unsigned ROM_SIZE_MAX = 1 << 20;
	localparam int unsigned BANK_BYTES = 16384;

	// top two address bits of the bank window and of the halt RAM area
	localparam logic [1:0] BANK_AREA = 2'b10;
	localparam logic [1:0] HALT_AREA = 2'b11;
	// lowest address of the hotspot page
	localparam logic [ADDR_W-1:0] HOTSPOT_BASE = 16'hFF80;
	// highest code the type register can hold; codes past MT_BS_HALTRAM are undefined
	localparam logic [TYPE_W-1:0] MT_TOP = '1;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} bus_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROMSZ_W-1:0] cfg_data = '0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [ADDR_W-1:0] bus_address = '0;
	logic [DATA_W-1:0] bus_data = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic rom_remap;
	logic [WIN_W-1:0] window_select;
	logic [BANK_W-1:0] rom_bank;
	logic exram_swap;
	logic exram_half;
	logic image_load;
	logic [OFS_W-1:0] image_offset;
	logic halt_write;
	logic [HADDR_W-1:0] halt_addr;
	logic [DATA_W-1:0] halt_data;

	cartridge_bank_switch_mapper dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bus_address(bus_address),
		.bus_data(bus_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rom_remap(rom_remap),
		.window_select(window_select),
		.rom_bank(rom_bank),
		.exram_swap(exram_swap),
		.exram_half(exram_half),
		.image_load(image_load),
		.image_offset(image_offset),
		.halt_write(halt_write),
		.halt_addr(halt_addr),
		.halt_data(halt_data)
	);

	// Mapper model: its own copy of the registers and of the mapping state.
	// Registers follow the configuration port, the state follows accepted writes.
	logic [TYPE_W-1:0] mapper_type_q = MT_NORMAL;
	logic [ROMSZ_W-1:0] rom_size_q = '0;
	map_state_t mapper_state = {BANK_NONE, 1'b0, 1'b0};

	// Pending write words, filled by the stimulus block, drained by the driver.
	bus_write_t pending_writes[$];
	// Decoded results waiting for their word on the output side.
	map_result_t predicted_results[$];

	bus_write_t next_write;
	map_result_t predicted;
	map_result_t oldest;

	int unsigned writes_queued = 0;
	int unsigned writes_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned remaps_seen = 0;
	int unsigned swaps_seen = 0;
	int unsigned image_loads_seen = 0;
	int unsigned halt_writes_seen = 0;
	int unsigned settings_used = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	// percentages of cycles in which the sender holds back or the receiver stalls
	int unsigned send_idle_pct = 19;
	int unsigned recv_stall_pct = 74;

	initial begin
		forever #6 clk = ~clk;
	end

	// Map a bank unless it is the one already mapped; a repeat leaves the result clear.
	function automatic map_result_t map_rom_bank(input map_result_t r,
		input logic [WIN_W-1:0] win, input logic [BANK_W-1:0] bank);
		if (bank != mapper_state.current_bank) begin
			mapper_state.current_bank = bank;
			r.rom_remap = 1'b1;
			r.window_select = win;
			r.rom_bank = bank;
		end
		return r;
	endfunction

	// Decode one CPU write against the current mapper type and advance the state.
	function automatic map_result_t decode_write(input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] data);
		map_result_t r;
		logic [1:0] area;
		r = '0;
		area = addr[ADDR_W-1 -: 2];
		case (mapper_type_q)
			MT_SUPERCART, MT_SC_RAM, MT_SC_RAMX2, MT_SC_ROM: begin
				if (area == BANK_AREA && mapper_type_q == MT_SC_RAMX2) begin
					// data bit 5 picks the RAM half, the low five bits the bank
					if (mapper_state.half_bit5 != data[5]) begin
						mapper_state.half_bit5 = data[5];
						r.exram_swap = 1'b1;
						r.exram_half = data[5];
					end
					r = map_rom_bank(r, WIN_8000, {3'b000, data[4:0]});
				end else if (area == BANK_AREA) begin
					r = map_rom_bank(r, WIN_8000, data);
				end else if (addr == ADDR_LAST && mapper_state.half_ffff != data[0]) begin
					mapper_state.half_ffff = data[0];
					r.exram_swap = 1'b1;
					r.exram_half = data[0];
				end
			end
			MT_LARGE: begin
				if (area == BANK_AREA)
					r = map_rom_bank(r, WIN_8000, data + 8'd1);
			end
			MT_ABSOLUTE: begin
				if (addr == ADDR_ABS_SWITCH && (data == 8'd1 || data == 8'd2))
					r = map_rom_bank(r, WIN_4000, data - 8'd1);
			end
			MT_HOTSPOT: begin
				if (addr >= HOTSPOT_BASE)
					r = map_rom_bank(r, WIN_A000, {5'b00000, addr[2:0]});
			end
			MT_BANKSETS, MT_BS_RAM, MT_BS_HALTRAM: begin
				if (area == BANK_AREA) begin
					// the second image sits past the first half of the ROM
					r = map_rom_bank(r, WIN_8000, data);
					r.image_load = 1'b1;
					r.image_offset = OFS_W'((rom_size_q >> 1) + data * BANK_BYTES);
				end else if (mapper_type_q == MT_BS_HALTRAM && area == HALT_AREA) begin
					r.halt_write = 1'b1;
					r.halt_addr = addr[HADDR_W-1:0];
					r.halt_data = data;
				end
			end
			default: begin
				// no banking: drop the write
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string label, input logic [OFS_W-1:0] want,
		input logic [OFS_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			fail_count++;
		end
	endtask

	// Wait at a falling edge until every queued word went in and every result came out.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (writes_accepted != writes_queued || predicted_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [ROMSZ_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		// the register takes the value at this edge; mirror it in the model
		case (idx)
			REG_MAPPER_TYPE: mapper_type_q = value[TYPE_W-1:0];
			REG_ROM_SIZE: rom_size_q = value;
			default: begin
			end
		endcase
	endtask

	// Reprogram both registers once the mapper has gone quiet; return at a falling edge.
	task automatic switch_mapper(input logic [TYPE_W-1:0] mtype,
		input logic [ROMSZ_W-1:0] size);
		wait_idle();
		write_register(REG_MAPPER_TYPE, {{(ROMSZ_W-TYPE_W){1'b0}}, mtype});
		write_register(REG_ROM_SIZE, size);
		settings_used++;
		@(negedge clk);
	endtask

	task automatic queue_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		pending_writes.push_back({addr, data});
		writes_queued++;
	endtask

	// Driver: present one write word at a time and hold it until it is taken.
	// The model decodes a word at the edge that accepts it, so its view of the
	// mapping state follows the order in which the block sees the writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			bus_address <= '0;
			bus_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted = decode_write(bus_address, bus_data);
				predicted_results.push_back(predicted);
				writes_accepted++;
				remaps_seen += predicted.rom_remap;
				swaps_seen += predicted.exram_swap;
				image_loads_seen += predicted.image_load;
				halt_writes_seen += predicted.halt_write;
			end
			// a stalled word stays put; otherwise advance or idle for a cycle
			if (!in_valid || !in_stall) begin
				if (pending_writes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_write = pending_writes.pop_front();
					in_valid <= 1'b1;
					bus_address <= next_write.addr;
					bus_data <= next_write.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take result words and compare each with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t ns: result word with no write pending, expected none, actual remap=%0d bank=%0d",
						$time, rom_remap, rom_bank);
					fail_count++;
				end else begin
					oldest = predicted_results.pop_front();
					check_field("rom_remap", OFS_W'(oldest.rom_remap), OFS_W'(rom_remap));
					check_field("window_select", OFS_W'(oldest.window_select),
						OFS_W'(window_select));
					check_field("rom_bank", OFS_W'(oldest.rom_bank), OFS_W'(rom_bank));
					check_field("exram_swap", OFS_W'(oldest.exram_swap), OFS_W'(exram_swap));
					check_field("exram_half", OFS_W'(oldest.exram_half), OFS_W'(exram_half));
					check_field("image_load", OFS_W'(oldest.image_load), OFS_W'(image_load));
					check_field("image_offset", oldest.image_offset, image_offset);
					check_field("halt_write", OFS_W'(oldest.halt_write), OFS_W'(halt_write));
					check_field("halt_addr", OFS_W'(oldest.halt_addr), OFS_W'(halt_addr));
					check_field("halt_data", OFS_W'(oldest.halt_data), OFS_W'(halt_data));
					results_checked++;
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: give up when no handshake of any kind has happened for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned counted;
		int unsigned seg;
		int unsigned seg_len;
		int unsigned pick;
		int unsigned n;
		logic [TYPE_W-1:0] mtype;
		logic [ROMSZ_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;

		// hold reset from time zero, release on a clock edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pass. Supercart: first map, same bank again, top bank,
		// RAM half from the last address, same half again, half back.
		switch_mapper(MT_SUPERCART, '0);
		queue_write(16'h8000, 8'h00);
		queue_write(16'h8000, 8'h00);
		queue_write(16'hBFFF, 8'hFF);
		queue_write(ADDR_LAST, 8'h01);
		queue_write(ADDR_LAST, 8'h01);
		queue_write(ADDR_LAST, 8'hFE);

		// Double RAM: bit 5 swaps the half, the bank keeps five bits only.
		switch_mapper(MT_SC_RAMX2, '0);
		queue_write(16'h8000, 8'h20);
		queue_write(16'hA000, 8'h3F);
		queue_write(16'h8000, 8'h1F);

		// Large: bank is data plus one, wrapping at the top.
		switch_mapper(MT_LARGE, '0);
		queue_write(16'h8000, 8'hFF);
		queue_write(16'h8000, 8'hFE);

		// Absolute: only data 1 and 2 at the switch address map a bank.
		switch_mapper(MT_ABSOLUTE, '0);
		queue_write(ADDR_ABS_SWITCH, 8'h01);
		queue_write(ADDR_ABS_SWITCH, 8'h02);
		queue_write(ADDR_ABS_SWITCH, 8'h03);
		queue_write(16'h8001, 8'h01);

		// Hotspot page: bank from the low address bits, page edges.
		switch_mapper(MT_HOTSPOT, '0);
		queue_write(HOTSPOT_BASE, 8'h00);
		queue_write(ADDR_LAST, 8'h00);

		// Halt RAM banksets at the largest ROM: image offset at its top, halt writes.
		switch_mapper(MT_BS_HALTRAM, ROMSZ_W'(ROM_SIZE_MAX));
		queue_write(16'hBFFF, 8'hFF);
		queue_write(16'hBFFF, 8'hFF);
		queue_write(16'hC000, 8'h00);
		queue_write(ADDR_LAST, 8'hFF);

		switch_mapper(MT_BANKSETS, '0);
		queue_write(16'h8000, 8'h00);

		// Types that do no banking, and an undefined code: the write is dropped.
		switch_mapper(MT_NORMAL, '0);
		queue_write(16'h8000, 8'h12);
		switch_mapper(MT_TOP, '0);
		queue_write(16'h8000, 8'h12);

		// Random pass: one setting per segment, every code once, then mostly banking types.
		counted = 0;
		seg = 0;
		while (counted < RANDOM_WRITES) begin
			if (seg <= MT_TOP) begin
				mtype = TYPE_W'(seg);
			end else if ($urandom_range(99) < 20) begin
				mtype = TYPE_W'($urandom_range(0, MT_TOP));
			end else begin
				do
					mtype = TYPE_W'($urandom_range(MT_SUPERCART, MT_BS_HALTRAM));
				while (mtype == MT_FLAT_ROM);
			end
			case ($urandom_range(3))
				0: size = '0;
				1: size = ROMSZ_W'(ROM_SIZE_MAX);
				2: size = ROMSZ_W'($urandom_range(0, ROM_SIZE_MAX));
				default: size = ROMSZ_W'($urandom_range(0, 64) * BANK_BYTES);
			endcase
			switch_mapper(mtype, size);

			// idling: sender light and receiver heavy, then swapped, then none
			if (counted < RANDOM_WRITES / 3) begin
				send_idle_pct = 19;
				recv_stall_pct = 74;
			end else if (counted < 2 * RANDOM_WRITES / 3) begin
				send_idle_pct = 74;
				recv_stall_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end

			// writes to non-banking types are merely dropped: keep those segments short
			if (mtype == MT_NORMAL || mtype == MT_FLAT_RAM || mtype == MT_FLAT_ROM
				|| mtype > MT_BS_HALTRAM)
				seg_len = IGNORED_SEGMENT_WRITES;
			else
				seg_len = SEGMENT_WRITES;

			for (n = 0; n < seg_len; n++) begin
				pick = $urandom_range(99);
				if (pick < 40)
					addr = {BANK_AREA, 14'($urandom)};
				else if (pick < 52)
					addr = ADDR_LAST;
				else if (pick < 62)
					addr = HOTSPOT_BASE - 16'd8 + 16'($urandom_range(0, 135));
				else if (pick < 70)
					addr = ADDR_ABS_SWITCH;
				else if (pick < 82)
					addr = {HALT_AREA, 14'($urandom)};
				else
					addr = 16'($urandom);
				// small values repeat banks and halves; bit 5 moves the double-RAM half
				pick = $urandom_range(99);
				if (pick < 35)
					data = 8'($urandom_range(0, 3));
				else if (pick < 50)
					data = {2'b00, 1'($urandom), 5'($urandom_range(0, 3))};
				else if (pick < 58)
					data = pick[0] ? 8'hFF : 8'h00;
				else
					data = 8'($urandom);
				queue_write(addr, data);
			end
			counted += seg_len;
			seg++;
		end

		// let the last results out, then watch for stray words
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d writes decoded under %0d mapper settings, %0d results compared",
			writes_accepted, settings_used, results_checked);
		$display("events: %0d bank remaps, %0d RAM half swaps, %0d image loads, %0d halt writes",
			remaps_seen, swaps_seen, image_loads_seen, halt_writes_seen);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
